@@ sv/pfpc_pkg.sv @@
// Shared types and constants for the pose frame parser with clamping.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package pfpc_pkg;

    // Burst framing
    localparam int POS_W       = 7;
    localparam int MAX_BURST   = 64;
    localparam int MIN_BURST   = 14;
    localparam int FIELD_FIRST = 4;
    localparam int FIELD_LAST  = 12;
    localparam int FIELD_N     = FIELD_LAST - FIELD_FIRST + 1;
    localparam int FIELD_IDX_W = $clog2(FIELD_N);
    localparam int HDR_LEN     = 4;

    localparam logic [POS_W-1:0] POS_SAT = '1;

    localparam logic [7:0] HDR_BYTE0 = 8'hFA;
    localparam logic [7:0] HDR_BYTE1 = 8'hFB;
    localparam logic [7:0] HDR_BYTE2 = 8'h04;
    localparam logic [7:0] HDR_BYTE3 = 8'h01;
    localparam logic [7:0] TRAILER   = 8'hFE;

    // Values and limits
    localparam int VAL_W   = 16;
    localparam int VAL_N   = 4;
    localparam int RAD_W   = 17;
    localparam int LIMIT_N = 2 * VAL_N;
    localparam int YAW_IDX = 3;

    // Yaw to negated radians: round(|yaw| * 8192 / 5730) by reciprocal multiply.
    localparam int RAD_FRAC    = 13;
    localparam int RAD_DEN     = 5730;
    localparam int RAD_HALF    = RAD_DEN / 2;
    localparam int NUM_W       = VAL_W + 1 + RAD_FRAC;
    localparam int RECIP_SHIFT = 42;
    localparam int RECIP_W     = 30;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(RAD_DEN) - 64'd1) / 64'(RAD_DEN));
    localparam int QUOT_W = 16;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_X_LO   = 3'd0,
        REG_X_HI   = 3'd1,
        REG_Y_LO   = 3'd2,
        REG_Y_HI   = 3'd3,
        REG_Z_LO   = 3'd4,
        REG_Z_HI   = 3'd5,
        REG_YAW_LO = 3'd6,
        REG_YAW_HI = 3'd7
    } cfg_reg_t;

    typedef logic signed [VAL_W-1:0] val_t;
    typedef val_t [VAL_N-1:0]   val_vec_t;
    typedef val_t [LIMIT_N-1:0] limit_vec_t;

    // One closed burst moving down the pipeline
    typedef struct packed {
        logic       valid;
        logic       ok;
        logic [7:0] mode;
        val_vec_t   vals;
    } frame_t;

    function automatic logic [7:0] hdr_byte(input logic [1:0] idx);
        logic [7:0] b;
        unique case (idx)
            2'd0:    b = HDR_BYTE0;
            2'd1:    b = HDR_BYTE1;
            2'd2:    b = HDR_BYTE2;
            default: b = HDR_BYTE3;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

@@ sv/pfpc_capture.sv @@
// Byte capture stage: tracks burst position and header, keeps the field bytes,
// and emits one frame record per burst end. Depends on pfpc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pfpc_capture (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            adv,
    input  wire logic            in_valid,
    input  wire logic [7:0]      in_byte,
    input  wire logic            in_last,
    output pfpc_pkg::frame_t     ev
);

    logic [pfpc_pkg::POS_W-1:0]       pos_reg, pos_next;
    logic                             hdr_good_reg, hdr_good_next;
    logic [7:0]                       field_reg [pfpc_pkg::FIELD_N];
    pfpc_pkg::frame_t                 ev_reg, ev_next;
    logic                             take;
    logic                             in_field;
    logic [pfpc_pkg::FIELD_IDX_W-1:0] field_idx;

    assign take      = adv && in_valid;
    assign in_field  = (pos_reg >= pfpc_pkg::POS_W'(pfpc_pkg::FIELD_FIRST)) &&
                       (pos_reg <= pfpc_pkg::POS_W'(pfpc_pkg::FIELD_LAST));
    assign field_idx = pfpc_pkg::FIELD_IDX_W'(pos_reg - pfpc_pkg::POS_W'(pfpc_pkg::FIELD_FIRST));

    always_comb
    begin
        pos_next      = pos_reg;
        hdr_good_next = hdr_good_reg;
        ev_next       = ev_reg;
        if (adv)
        begin
            ev_next.valid = 1'b0;
        end
        if (take)
        begin
            if (in_last)
            begin
                // close the burst and restart framing
                ev_next.valid = 1'b1;
                ev_next.ok    = hdr_good_reg && (in_byte == pfpc_pkg::TRAILER) &&
                    (pos_reg >= pfpc_pkg::POS_W'(pfpc_pkg::MIN_BURST - 1)) &&
                    (pos_reg <= pfpc_pkg::POS_W'(pfpc_pkg::MAX_BURST - 1));
                ev_next.mode  = field_reg[0];
                for (int k = 0; k < pfpc_pkg::VAL_N; k++)
                begin
                    ev_next.vals[k] = {field_reg[2*k+1], field_reg[2*k+2]};
                end
                pos_next      = '0;
                hdr_good_next = 1'b1;
            end
            else
            begin
                if (pos_reg < pfpc_pkg::POS_W'(pfpc_pkg::HDR_LEN) &&
                    in_byte != pfpc_pkg::hdr_byte(pos_reg[1:0]))
                begin
                    hdr_good_next = 1'b0;
                end
                if (pos_reg != pfpc_pkg::POS_SAT)
                begin
                    pos_next = pos_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            hdr_good_reg <= 1'b1;
            ev_reg       <= '0;
        end
        else
        begin
            pos_reg      <= pos_next;
            hdr_good_reg <= hdr_good_next;
            ev_reg       <= ev_next;
        end
    end

    // field bytes need no reset: every one is written before an accepted burst reads it
    always_ff @(posedge clk)
    begin
        if (take && in_field)
        begin
            field_reg[field_idx] <= in_byte;
        end
    end

    assign ev = ev_reg;

    a_pos_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (take && in_last) |=> (pos_reg == '0 && hdr_good_reg))
        else $error("burst position not restarted after burst end");

    a_short_reject: assert property (@(posedge clk) disable iff (!rst_n)
        (take && in_last && pos_reg < pfpc_pkg::POS_W'(pfpc_pkg::MIN_BURST - 1))
        |=> !ev_reg.ok)
        else $error("short burst accepted");

endmodule

`default_nettype wire

@@ sv/pfpc_clamp.sv @@
// Clamp stage: limits each decoded value to its configured low and high bound.
// Depends on pfpc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pfpc_clamp (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 adv,
    input  wire pfpc_pkg::frame_t     ev,
    input  wire pfpc_pkg::limit_vec_t limits,
    output pfpc_pkg::frame_t          cl
);

    pfpc_pkg::frame_t cl_reg, cl_next;
    pfpc_pkg::val_t   v, lo, hi;

    always_comb
    begin
        cl_next = cl_reg;
        v  = '0;
        lo = '0;
        hi = '0;
        if (adv)
        begin
            cl_next.valid = ev.valid;
            cl_next.ok    = ev.ok;
            cl_next.mode  = ev.mode;
            for (int k = 0; k < pfpc_pkg::VAL_N; k++)
            begin
                v  = $signed(ev.vals[k]);
                lo = $signed(limits[2*k]);
                hi = $signed(limits[2*k+1]);
                // when the limits cross, a value below the low bound gives the low bound and any other the high bound
                priority if (v < lo)
                    cl_next.vals[k] = lo;
                else if (v > hi)
                    cl_next.vals[k] = hi;
                else
                    cl_next.vals[k] = v;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cl_reg <= '0;
        end
        else
        begin
            cl_reg <= cl_next;
        end
    end

    assign cl = cl_reg;

endmodule

`default_nettype wire

@@ sv/pfpc_yaw.sv @@
// Yaw conversion and hold stage: reciprocal multiply for negated radians,
// then the held-value result register. Depends on pfpc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pfpc_yaw (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                adv,
    input  wire pfpc_pkg::frame_t                    cl,
    output logic                                     out_valid,
    output logic                                     out_ok,
    output logic [7:0]                               held_mode,
    output pfpc_pkg::val_vec_t                       held_vals,
    output logic signed [pfpc_pkg::RAD_W-1:0]        held_rad
);

    pfpc_pkg::frame_t                       s3_reg;
    logic                                   neg_reg;
    logic [pfpc_pkg::QUOT_W-1:0]            quot_reg;
    logic [pfpc_pkg::VAL_W:0]               yaw_ext, yaw_mag;
    logic [pfpc_pkg::NUM_W-1:0]             num;
    logic [pfpc_pkg::NUM_W+pfpc_pkg::RECIP_W-1:0] prod;
    logic                                   yaw_pos;

    logic                                   out_valid_reg;
    logic                                   ok_reg;
    logic [7:0]                             mode_reg;
    pfpc_pkg::val_vec_t                     vals_reg;
    logic signed [pfpc_pkg::RAD_W-1:0]      rad_reg;
    logic signed [pfpc_pkg::RAD_W-1:0]      rad_next;
    logic                                   hold_load;

    // magnitude of yaw, scaled by 2^13 with half the divisor added for rounding
    assign yaw_ext = {cl.vals[pfpc_pkg::YAW_IDX][pfpc_pkg::VAL_W-1], cl.vals[pfpc_pkg::YAW_IDX]};
    assign yaw_mag = yaw_ext[pfpc_pkg::VAL_W] ? (~yaw_ext + 1'b1) : yaw_ext;
    assign yaw_pos = !yaw_ext[pfpc_pkg::VAL_W] && (|yaw_ext);
    assign num     = {yaw_mag, {pfpc_pkg::RAD_FRAC{1'b0}}} +
                     pfpc_pkg::NUM_W'(pfpc_pkg::RAD_HALF);
    assign prod    = num * pfpc_pkg::RECIP;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_reg   <= '0;
            neg_reg  <= 1'b0;
            quot_reg <= '0;
        end
        else if (adv)
        begin
            s3_reg   <= cl;
            neg_reg  <= yaw_pos;
            quot_reg <= prod[pfpc_pkg::RECIP_SHIFT +: pfpc_pkg::QUOT_W];
        end
    end

    // positive yaw gives negative radians
    assign rad_next  = neg_reg ? -$signed({1'b0, quot_reg}) : $signed({1'b0, quot_reg});
    assign hold_load = adv && s3_reg.valid && s3_reg.ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            ok_reg        <= 1'b0;
            mode_reg      <= '0;
            vals_reg      <= '0;
            rad_reg       <= '0;
        end
        else
        begin
            if (adv)
            begin
                out_valid_reg <= s3_reg.valid;
                ok_reg        <= s3_reg.ok;
            end
            if (hold_load)
            begin
                mode_reg <= s3_reg.mode;
                vals_reg <= s3_reg.vals;
                rad_reg  <= rad_next;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_ok    = ok_reg;
    assign held_mode = mode_reg;
    assign held_vals = vals_reg;
    assign held_rad  = rad_reg;

    a_hold_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !hold_load |=> ($stable(vals_reg) && $stable(rad_reg) && $stable(mode_reg)))
        else $error("held values changed without an accepted frame");

    a_rad_sign: assert property (@(posedge clk) disable iff (!rst_n)
        !($signed(vals_reg[pfpc_pkg::YAW_IDX]) > 0 && rad_reg > 0) &&
        !($signed(vals_reg[pfpc_pkg::YAW_IDX]) < 0 && rad_reg < 0))
        else $error("radian yaw sign does not oppose held yaw");

endmodule

`default_nettype wire

@@ sv/pose_frame_parser_clamp.sv @@
// Pose frame parser with clamping: top level with input skid stage and limit registers.
// Instantiates pfpc_capture, pfpc_clamp, pfpc_yaw; depends on pfpc_pkg.
//
// Usage:
//   Slave stream (s_*): one received serial byte per transfer in s_tdata[7:0],
//   s_tlast high on the last byte of a read burst.
//   Master stream (m_*): one result per burst end, none for other bytes.
//   m_tuser is the accept flag of that burst; m_tdata carries the mode byte and
//   the held clamped x, y, z, yaw and negated yaw in radians (Q3.13).
//   A rejected burst repeats the values of the last accepted one.
//   Config port: cfg_we writes cfg_data to limit register cfg_index; write only
//   while the block is idle.
// Timing:
//   One byte per cycle sustained while the result register is free or being
//   taken. A result appears on m_tvalid after the closing byte passes the capture,
//   clamp and reciprocal multiply stages, then the result register.
// Reset: limits, held values and burst framing clear; s_tready rises at once.
// Stall: while m_tready is low and a result waits, the pipeline holds; one more
//   byte is caught in the skid register, then s_tready drops until the result
//   is taken.
`timescale 1ns / 1ps
`default_nettype none

module pose_frame_parser_clamp (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // slave stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  wire logic        s_tlast,   // burst_end
    // master stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [95:0]      m_tdata,   // [7:0] mode_byte, [23:8] pos_x_mm, [39:24] pos_y_mm,
                                        // [55:40] pos_z_mm, [71:56] yaw_centideg,
                                        // [88:72] yaw_rad_q13, [95:89] zero
    output logic             m_tuser,   // frame_ok
    // configuration
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    pfpc_pkg::limit_vec_t               limit_reg;
    logic                               skid_valid_reg, skid_valid_next;
    logic [7:0]                         skid_byte_reg;
    logic                               skid_last_reg;
    logic                               adv;
    logic                               s_take;
    logic                               item_valid;
    logic [7:0]                         item_byte;
    logic                               item_last;
    pfpc_pkg::frame_t                   ev;
    pfpc_pkg::frame_t                   cl;
    logic                               out_valid;
    logic                               out_ok;
    logic [7:0]                         held_mode;
    pfpc_pkg::val_vec_t                 held_vals;
    logic signed [pfpc_pkg::RAD_W-1:0]  held_rad;

    // limit registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= '0;
        end
        else if (cfg_we)
        begin
            limit_reg[cfg_index] <= cfg_data;
        end
    end

    // advance the pipeline whenever the result register is free or being taken
    assign adv      = !out_valid || m_tready;
    assign s_tready = !skid_valid_reg;
    assign s_take   = s_tvalid && s_tready;

    assign item_valid = skid_valid_reg || s_take;
    assign item_byte  = skid_valid_reg ? skid_byte_reg : s_tdata;
    assign item_last  = skid_valid_reg ? skid_last_reg : s_tlast;

    always_comb
    begin
        skid_valid_next = skid_valid_reg;
        if (adv)
        begin
            skid_valid_next = 1'b0;
        end
        else if (s_take)
        begin
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!adv && s_take)
        begin
            skid_byte_reg <= s_tdata;
            skid_last_reg <= s_tlast;
        end
    end

    pfpc_capture u_capture (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (item_valid),
        .in_byte  (item_byte),
        .in_last  (item_last),
        .ev       (ev)
    );

    pfpc_clamp u_clamp (
        .clk    (clk),
        .rst_n  (rst_n),
        .adv    (adv),
        .ev     (ev),
        .limits (limit_reg),
        .cl     (cl)
    );

    pfpc_yaw u_yaw (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .cl        (cl),
        .out_valid (out_valid),
        .out_ok    (out_ok),
        .held_mode (held_mode),
        .held_vals (held_vals),
        .held_rad  (held_rad)
    );

    assign m_tvalid = out_valid;
    assign m_tuser  = out_ok;
    assign m_tdata  = {7'b0, held_rad, held_vals[3], held_vals[2], held_vals[1],
                       held_vals[0], held_mode};

    a_skid_implies_stall: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid)
        else $error("skid register holds a byte while the result register is empty");

    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (s_take && !adv) |=> (skid_valid_reg && !s_tready))
        else $error("transfer during stall not held in skid register");

endmodule

`default_nettype wire
